[src/box_average_image_resize_core_assert.svh]
// Assertion macros shared by the resize core.
`ifndef BOX_AVERAGE_IMAGE_RESIZE_CORE_ASSERT_SVH
`define BOX_AVERAGE_IMAGE_RESIZE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BAIR_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked on the following clock edge.
`define BAIR_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/bair_pkg.sv]
// Package of types and constants for the box average image resize core.
`timescale 1ns / 1ps
package bair_pkg;
    localparam int MAX_WIDTH = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int SW = XW + YW + 8;
    localparam int CW = XW + YW + 1;
    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIVA, ST_DIVB, ST_WALK, ST_DIV, ST_OUT, ST_PICK
    } state_t;
endpackage

[src/box_average_image_resize_core.sv]
// Box average image resize core: top level with frame store and sequencer.
// The block holds a source frame of up to 64 by 64 RGB pixels in one
// synchronous memory with a registered read port. Items arrive on the
// in channel (valid/ready). A load item (kind 0) writes a pixel and
// gives no result; a load outside the source size is dropped.
// A request item (kind 1) names a destination pixel. The sequencer first
// finds the box corners with a shared restoring divider (first for x,
// then for y), then walks the box one pixel per cycle through the
// memory port, then divides the three channel sums by the pixel count
// with restoring dividers, one per channel. Nearest mode reads the
// top-left pixel instead of the walk and the divide; an out-of-range
// request goes to its result in the next cycle.
// The result waits in an output register until the receiver takes it;
// the next item is accepted in the cycle the result is taken.
// Registers sit on an APB port at byte addresses 4*i; pready is always high.
// Reset clears control state and sets the registers to 64,64,64,64,1;
// the frame store contents stay undefined until loaded.
`timescale 1ns / 1ps
`include "box_average_image_resize_core_assert.svh"
module box_average_image_resize_core
    import bair_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [5:0]  coord_x,
    input  logic [5:0]  coord_y,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        bad_coord
);
    logic [6:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic       mode_reg;
    logic [2:0] ridx;
    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 7'd64;
            sh_reg <= 7'd64;
            dw_reg <= 7'd64;
            dh_reg <= 7'd64;
            mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_SRC_W: sw_reg <= pwdata[6:0];
                REG_SRC_H: sh_reg <= pwdata[6:0];
                REG_DST_W: dw_reg <= pwdata[6:0];
                REG_DST_H: dh_reg <= pwdata[6:0];
                REG_MODE:  mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_SRC_W: prdata = {25'd0, sw_reg};
            REG_SRC_H: prdata = {25'd0, sh_reg};
            REG_DST_W: prdata = {25'd0, dw_reg};
            REG_DST_H: prdata = {25'd0, dh_reg};
            REG_MODE:  prdata = {31'd0, mode_reg};
            default:   prdata = 32'd0;
        endcase
    end

    function automatic logic [6:0] clampv(input logic [6:0] v, input logic [6:0] m);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) r = 7'd1;
        else if (v > m) r = m;
        return r;
    endfunction

    logic [6:0] sw, sh, dw, dh;
    assign sw = clampv(sw_reg, 7'(MAX_WIDTH));
    assign sh = clampv(sh_reg, 7'(MAX_HEIGHT));
    assign dw = clampv(dw_reg, 7'(MAX_WIDTH));
    assign dh = clampv(dh_reg, 7'(MAX_HEIGHT));

    // Frame store.
    logic [23:0] mem [0:(1 << AW) - 1];
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0] mem_rdata_reg;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= {in_red, in_green, in_blue};
        mem_rdata_reg <= mem[mem_raddr];
    end

    state_t state_reg, state_next;
    logic [5:0] cx_reg, cy_reg;
    logic [5:0] xa_reg, ya_reg, xb_reg, yb_reg, x_reg, y_reg;
    logic       rd_pend_reg, last_reg;
    logic [SW-1:0] sr_reg, sg_reg, sb_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0] or_reg, og_reg, ob_reg;
    logic       bad_reg;
    // Corner divider: dividend (c*s) and (c+1)*s, divisor d, 13 quotient bits.
    logic [12:0] dq0_reg, dq1_reg;
    logic [6:0]  dr0_reg, dr1_reg;
    logic [4:0]  step_reg;
    // Channel divider.
    logic [SW-1:0] qr_reg, qg_reg, qb_reg;
    logic [CW-1:0] rr_reg, rg_reg, rb_reg;
    // Nearest mode: the walk is skipped, so a small pick stage reads mem.
    logic          pick_reg;

    logic acc_in, acc_out;
    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_OUT && out_ready);
    assign acc_in = in_valid && in_ready;
    assign acc_out = out_valid && out_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_red = or_reg;
    assign out_green = og_reg;
    assign out_blue = ob_reg;
    assign bad_coord = bad_reg;

    logic is_req, req_bad;
    assign is_req = kind;
    assign req_bad = ({1'b0, coord_x} >= dw) || ({1'b0, coord_y} >= dh);
    assign mem_we = acc_in && !kind && ({1'b0, coord_x} < sw) && ({1'b0, coord_y} < sh);
    assign mem_waddr = {coord_y[YW-1:0], coord_x[XW-1:0]};
    assign mem_raddr = {y_reg[YW-1:0], x_reg[XW-1:0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (state_reg == ST_OUT && out_ready) state_next = ST_IDLE;
                if (acc_in && is_req) state_next = req_bad ? ST_OUT : ST_DIVA;
            end
            ST_DIVA: if (step_reg == 5'd12) state_next = ST_DIVB;
            ST_DIVB: if (step_reg == 5'd12) state_next = mode_reg ? ST_WALK : ST_PICK;
            ST_WALK: if (last_reg && rd_pend_reg) state_next = ST_DIV;
            ST_DIV:  if (step_reg == 5'(SW - 1)) state_next = ST_OUT;
            ST_PICK: if (pick_reg) state_next = ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // One restoring step: remainder r, next dividend bit b, divisor d.
    logic [12:0] n0, n1;
    logic [7:0]  t0, t1;
    logic [5:0]  cx1;
    logic [3:0]  bidx;
    assign bidx = 4'(5'd12 - step_reg);
    always_comb
    begin
        cx1 = (state_reg == ST_DIVA) ? cx_reg : cy_reg;
        n0 = 13'(cx1) * ((state_reg == ST_DIVA) ? 13'(sw) : 13'(sh));
        n1 = 13'(cx1 + 7'd1) * ((state_reg == ST_DIVA) ? 13'(sw) : 13'(sh));
        t0 = {dr0_reg, n0[bidx]};
        t1 = {dr1_reg, n1[bidx]};
    end
    logic [6:0] dd;
    assign dd = (state_reg == ST_DIVA) ? dw : dh;
    logic [7:0] s0, s1;
    assign s0 = t0 - {1'b0, dd};
    assign s1 = t1 - {1'b0, dd};
    logic [12:0] q0f, q1f;
    assign q0f = {dq0_reg[11:0], !s0[7]};
    assign q1f = {dq1_reg[11:0], !s1[7]};
    logic [5:0] lim_x, lim_y;
    assign lim_x = 6'(sw - 7'd1);
    assign lim_y = 6'(sh - 7'd1);

    function automatic logic [CW:0] cstep(input logic [CW-1:0] r, input logic b,
                                           input logic [CW-1:0] d);
        logic [CW:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) return {1'b1, CW'(t - {1'b0, d})};
        return {1'b0, t[CW-1:0]};
    endfunction
    logic [CW:0] rsr, rsg, rsb;
    assign rsr = cstep(rr_reg, qr_reg[SW-1], cnt_reg);
    assign rsg = cstep(rg_reg, qg_reg[SW-1], cnt_reg);
    assign rsb = cstep(rb_reg, qb_reg[SW-1], cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            last_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            case (state_reg)
                ST_DIVA, ST_DIVB:
                begin
                    step_reg <= (step_reg == 5'd12) ? 5'd0 : step_reg + 5'd1;
                    rd_pend_reg <= 1'b0;
                    last_reg <= 1'b0;
                end
                ST_WALK:
                begin
                    rd_pend_reg <= !last_reg;
                    if (x_reg == xb_reg && y_reg == yb_reg) last_reg <= 1'b1;
                    if (last_reg && rd_pend_reg) step_reg <= 5'd0;
                end
                ST_DIV: step_reg <= step_reg + 5'd1;
                default:
                begin
                    step_reg <= 5'd0;
                    rd_pend_reg <= 1'b0;
                    last_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIVA, ST_DIVB:
            begin
                dr0_reg <= (step_reg == 5'd12) ? 7'd0 : (s0[7] ? t0[6:0] : s0[6:0]);
                dr1_reg <= (step_reg == 5'd12) ? 7'd0 : (s1[7] ? t1[6:0] : s1[6:0]);
                dq0_reg <= q0f;
                dq1_reg <= q1f;
                if (step_reg == 5'd12)
                begin
                    if (state_reg == ST_DIVA)
                    begin
                        xa_reg <= q0f[5:0];
                        x_reg <= q0f[5:0];
                        xb_reg <= (q1f >= 13'(sw)) ? lim_x : q1f[5:0];
                    end
                    else
                    begin
                        ya_reg <= q0f[5:0];
                        y_reg <= q0f[5:0];
                        yb_reg <= (q1f >= 13'(sh)) ? lim_y : q1f[5:0];
                    end
                end
            end
            ST_WALK:
            begin
                if (!last_reg && !(x_reg == xb_reg && y_reg == yb_reg))
                begin
                    if (x_reg == xb_reg)
                    begin
                        x_reg <= xa_reg;
                        y_reg <= y_reg + 6'd1;
                    end
                    else
                        x_reg <= x_reg + 6'd1;
                end
                if (rd_pend_reg)
                begin
                    sr_reg <= sr_reg + SW'(mem_rdata_reg[23:16]);
                    sg_reg <= sg_reg + SW'(mem_rdata_reg[15:8]);
                    sb_reg <= sb_reg + SW'(mem_rdata_reg[7:0]);
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (last_reg && rd_pend_reg)
                begin
                    qr_reg <= sr_reg + SW'(mem_rdata_reg[23:16]);
                    qg_reg <= sg_reg + SW'(mem_rdata_reg[15:8]);
                    qb_reg <= sb_reg + SW'(mem_rdata_reg[7:0]);
                    rr_reg <= '0;
                    rg_reg <= '0;
                    rb_reg <= '0;
                end
            end
            ST_DIV:
            begin
                qr_reg <= {qr_reg[SW-2:0], rsr[CW]};
                qg_reg <= {qg_reg[SW-2:0], rsg[CW]};
                qb_reg <= {qb_reg[SW-2:0], rsb[CW]};
                rr_reg <= rsr[CW-1:0];
                rg_reg <= rsg[CW-1:0];
                rb_reg <= rsb[CW-1:0];
                if (step_reg == 5'(SW - 1))
                begin
                    or_reg <= {qr_reg[6:0], rsr[CW]};
                    og_reg <= {qg_reg[6:0], rsg[CW]};
                    ob_reg <= {qb_reg[6:0], rsb[CW]};
                end
            end
            ST_PICK:
            begin
                // The registered read of the top-left pixel is taken once pick_reg is set.
                if (pick_reg)
                begin
                    or_reg <= nn_pix[23:16];
                    og_reg <= nn_pix[15:8];
                    ob_reg <= nn_pix[7:0];
                end
            end
            default: ;
        endcase
        if (state_reg == ST_DIVB && step_reg == 5'd12 && !mode_reg)
        begin
            // Nearest mode reads the top-left pixel directly.
            x_reg <= xa_reg;
        end
        if (state_reg == ST_DIVB && step_reg == 5'd12)
        begin
            sr_reg <= '0;
            sg_reg <= '0;
            sb_reg <= '0;
            cnt_reg <= '0;
        end
        if (acc_in && is_req)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            bad_reg <= req_bad;
            dr0_reg <= 7'd0;
            dr1_reg <= 7'd0;
            or_reg <= 8'd0;
            og_reg <= 8'd0;
            ob_reg <= 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pick_reg <= 1'b0;
        else
            pick_reg <= (state_reg == ST_PICK) && !pick_reg;
    end
    logic [23:0] nn_pix;
    assign nn_pix = mem_rdata_reg;

    `BAIR_ASSERT_IMP(a_no_in_busy, state_reg == ST_WALK || state_reg == ST_DIV, !in_ready)
    `BAIR_ASSERT_IMP(a_bad_zero, out_valid && bad_coord,
        out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    `BAIR_ASSERT_NEXT(a_out_after, acc_out && !acc_in, state_reg == ST_IDLE)
endmodule
